// ===== rtl/shamh_pkg.sv =====
package shamh_pkg;

   // One input word: a message byte and its framing marks.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   // One result word: a digest word with its position.
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] INIT_H [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;
   localparam logic [5:0] LAST_POS = 6'd63;

endpackage

// ===== rtl/sha256_message_hasher_top.sv =====
// A byte that fills the 64-byte block starts a busy phase with req_stall high: a load of the
// working variables, 64 rounds and one chaining add.
// Long messages are bounded by the single round unit: no bytes are taken while a block is
// compressed. Closing: padding bytes one per cycle up to the block end, possibly one extra
// block, then the eight digest words at one per cycle while rsp_stall is low.
// Reset (synchronous, active high) loads the initial hash values and clears the bit count.
module sha256_message_hasher_top
   import shamh_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   // Sequencer states.
   localparam logic [2:0] ST_IDLE  = 3'd0;  // taking message bytes
   localparam logic [2:0] ST_PAD   = 3'd1;  // writing padding and length bytes
   localparam logic [2:0] ST_START = 3'd2;  // first schedule read, load working variables
   localparam logic [2:0] ST_ROUND = 3'd3;  // 64 compression rounds
   localparam logic [2:0] ST_ADD   = 3'd4;  // fold working variables into the chain
   localparam logic [2:0] ST_OUT   = 3'd5;  // hand out the eight digest words

   logic [2:0]  state_ff, state_in;
   logic [5:0]  pos_ff, pos_in;          // byte position inside the current block
   logic [23:0] word_ff, word_in;        // bytes of the word being assembled
   logic [63:0] bitlen_ff, bitlen_in;    // message length in bits, wraps
   logic        pad_ff, pad_in;          // message closed, padding under way
   logic        mark_ff, mark_in;        // the 0x80 marker is still to be written
   logic        lblk_ff, lblk_in;        // this block carries the length field
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];
   logic [31:0] vars_ff [8];
   logic [31:0] vars_in [8];
   logic [31:0] win_ff [16];             // last sixteen schedule words, oldest first
   logic [31:0] win_in [16];

   logic        byte_wr;
   logic [7:0]  wbyte;
   logic [63:0] len_shift;
   logic [7:0]  len_byte;

   logic        ram_wr_en;
   logic [3:0]  ram_wr_addr;
   logic [31:0] ram_wr_data;
   logic [3:0]  ram_rd_addr;
   logic [31:0] ram_rd_data;

   logic [31:0] w_new;
   logic [31:0] wt;
   logic [31:0] t1;
   logic [31:0] t2;

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      big_sig0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      big_sig1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] sml_sig0(input logic [31:0] x);
      sml_sig0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] sml_sig1(input logic [31:0] x);
      sml_sig1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

   // The 16-entry block memory holds the message words as they are assembled.
   // During rounds 0 to 15 it is read one word ahead of the round that uses it;
   // later schedule words come from the sliding window in flip-flops.
   shamh_ram #(
      .WIDTH(32),
      .DEPTH(16)
   ) u_block_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // The length field goes out most significant byte first at positions 56 to 63.
   assign len_shift = bitlen_ff >> {~pos_ff[2:0], 3'b000};
   assign len_byte  = len_shift[7:0];

   // A word is written once its fourth byte arrives; no read can hit it before
   // the block is full, so no forwarding is needed.
   assign ram_wr_en   = byte_wr && (pos_ff[1:0] == 2'b11);
   assign ram_wr_addr = pos_ff[5:2];
   assign ram_wr_data = {word_ff, wbyte};
   assign ram_rd_addr = (state_ff == ST_ROUND) ? (rnd_ff[3:0] + 4'd1) : 4'd0;

   // One compression round.
   always_comb begin
      w_new = sml_sig1(win_ff[14]) + win_ff[9] + sml_sig0(win_ff[1]) + win_ff[0];
      wt    = (rnd_ff[5:4] == 2'b00) ? ram_rd_data : w_new;
      t1    = vars_ff[7] + big_sig1(vars_ff[4])
            + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
            + ROUND_K[rnd_ff] + wt;
      t2    = big_sig0(vars_ff[0])
            + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
               ^ (vars_ff[1] & vars_ff[2]));
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      word_in   = word_ff;
      bitlen_in = bitlen_ff;
      pad_in    = pad_ff;
      mark_in   = mark_ff;
      lblk_in   = lblk_ff;
      rnd_in    = rnd_ff;
      oidx_in   = oidx_ff;
      chain_in  = chain_ff;
      vars_in   = vars_ff;
      win_in    = win_ff;
      byte_wr   = 1'b0;
      wbyte     = 8'h00;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_item.byte_present) begin
                  byte_wr   = 1'b1;
                  wbyte     = req_item.data_byte;
                  bitlen_in = bitlen_ff + 64'd8;
               end
               if (req_item.end_of_message) begin
                  pad_in  = 1'b1;
                  mark_in = 1'b1;
               end
               // A byte that fills the block is compressed before any padding.
               if (req_item.byte_present && (pos_ff == LAST_POS)) begin
                  state_in = ST_START;
               end else if (req_item.end_of_message) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            byte_wr = 1'b1;
            if (mark_ff) begin
               wbyte   = PAD_MARK;
               mark_in = 1'b0;
               // The length fits behind the marker only if the marker lands
               // before the length field.
               lblk_in = (pos_ff < LEN_POS);
            end else if (lblk_ff && (pos_ff >= LEN_POS)) begin
               wbyte = len_byte;
            end
            if (pos_ff == LAST_POS) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            vars_in  = chain_ff;
            rnd_in   = 6'd0;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            vars_in[7] = vars_ff[6];
            vars_in[6] = vars_ff[5];
            vars_in[5] = vars_ff[4];
            vars_in[4] = vars_ff[3] + t1;
            vars_in[3] = vars_ff[2];
            vars_in[2] = vars_ff[1];
            vars_in[1] = vars_ff[0];
            vars_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               win_in[i] = win_ff[i + 1];
            end
            win_in[15] = wt;
            rnd_in     = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int j = 0; j < 8; j++) begin
               chain_in[j] = chain_ff[j] + vars_ff[j];
            end
            if (pad_ff && lblk_ff) begin
               oidx_in  = 3'd0;
               state_in = ST_OUT;
            end else if (pad_ff) begin
               // The next padding block always has room for the length field.
               lblk_in  = 1'b1;
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  // Start over with a fresh message.
                  chain_in  = INIT_H;
                  bitlen_in = 64'd0;
                  pad_in    = 1'b0;
                  mark_in   = 1'b0;
                  lblk_in   = 1'b0;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (byte_wr) begin
         pos_in  = pos_ff + 6'd1;
         word_in = {word_ff[15:0], wbyte};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pos_ff    <= 6'd0;
         bitlen_ff <= 64'd0;
         pad_ff    <= 1'b0;
         mark_ff   <= 1'b0;
         lblk_ff   <= 1'b0;
         rnd_ff    <= 6'd0;
         oidx_ff   <= 3'd0;
         chain_ff  <= INIT_H;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         bitlen_ff <= bitlen_in;
         pad_ff    <= pad_in;
         mark_ff   <= mark_in;
         lblk_ff   <= lblk_in;
         rnd_ff    <= rnd_in;
         oidx_ff   <= oidx_in;
         chain_ff  <= chain_in;
      end
      word_ff <= word_in;
      vars_ff <= vars_in;
      win_ff  <= win_in;
   end

   // Input words are taken only while the sequencer waits for message bytes.
   assign req_stall = (state_ff != ST_IDLE);

   // The digest words are read straight from the chaining registers, which
   // hold still for the whole output phase.
   assign rsp_valid            = (state_ff == ST_OUT);
   assign rsp_item.digest_word = chain_ff[oidx_ff];
   assign rsp_item.word_index  = oidx_ff;
   assign rsp_item.last_word   = (oidx_ff == 3'd7);

   a_out_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while digest words are pending");

   a_full_block_compresses: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_item.byte_present && (pos_ff == LAST_POS))
      |=> (state_ff == ST_START))
      else $error("full block did not start a compression");

   a_rounds_end: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_ROUND) && (rnd_ff == 6'd63)) |=> (state_ff == ST_ADD))
      else $error("round sequence did not end after 64 rounds");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_item.last_word)
      |=> ((bitlen_ff == 64'd0) && (pos_ff == 6'd0) && (chain_ff[0] == INIT_H[0])))
      else $error("hasher did not return to its initial state after the digest");

endmodule

// ===== rtl/shamh_ram.sv =====
module shamh_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
